### rtl/gbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg: shared constants
// Defaults and widths used by the front, the back and the top level.
// ----------------------------------------------------------------------------
package gbs_pkg;
	localparam int MaxBoxesDefault = 64;
	localparam int CoordBitsDefault = 16;
	localparam int ThrBits = 9;
	localparam logic [ThrBits-1:0] ThrReset = 9'd128;
	localparam int IndexBits = 6;
endpackage

### rtl/gbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ram: generic single-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbs_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/gbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_front: box loader
// Accepts boxes, stores them and queues a set-end request for the back.
// ----------------------------------------------------------------------------
module gbs_front #(
	parameter int MaxBoxes = gbs_pkg::MaxBoxesDefault,
	parameter int CoordBits = gbs_pkg::CoordBitsDefault,
	localparam int AW = $clog2(MaxBoxes),
	localparam int CW = $clog2(MaxBoxes + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [4*CoordBits-1:0] in_box,
	input  logic                 in_last,
	input  logic                 set_busy,
	output logic                 we,
	output logic [AW-1:0]        waddr,
	output logic [4*CoordBits-1:0] wdata,
	output logic                 req_valid,
	input  logic                 req_ready,
	output logic [CW-1:0]        req_count,
	output logic                 req_ovf
);
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          acc;
	logic          full;
	logic [CW-1:0] count_nx;

	assign full = count_q == CW'(MaxBoxes);
	assign in_ready = !set_busy && !req_valid;
	assign acc = in_valid && in_ready;
	assign we = acc && !full;
	assign waddr = count_q[AW-1:0];
	assign wdata = in_box;
	assign count_nx = full ? count_q : count_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			req_valid <= 1'b0;
			req_count <= '0;
			req_ovf <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				req_valid <= 1'b0;
			end
			if (acc) begin
				if (in_last) begin
					req_valid <= 1'b1;
					req_count <= count_nx;
					req_ovf <= ovf_q || full;
					count_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					count_q <= count_nx;
					ovf_q <= ovf_q || full;
				end
			end
		end
	end

`ifndef SYNTH
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		set_busy |-> !acc) else $error("box accepted while set busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MaxBoxes)) else $error("count beyond capacity");
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid) else $error("request lost");
`endif
endmodule

### rtl/gbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_back: suppression engine
// Walks box pairs, one IoU test at a time through RDJ, MUL, UNI and TEST, then emits surviving boxes.
// ----------------------------------------------------------------------------
module gbs_back #(
	parameter int MaxBoxes = gbs_pkg::MaxBoxesDefault,
	parameter int CoordBits = gbs_pkg::CoordBitsDefault,
	localparam int AW = $clog2(MaxBoxes),
	localparam int CW = $clog2(MaxBoxes + 1),
	localparam int BW = 4*CoordBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [gbs_pkg::ThrBits-1:0] thr,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [CW-1:0]         req_count,
	input  logic                  req_ovf,
	output logic                  busy,
	output logic [AW-1:0]         raddr,
	input  logic [BW-1:0]         rdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AW-1:0]         out_idx,
	output logic [BW-1:0]         out_box,
	output logic                  out_ovf,
	output logic                  out_last
);
	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001, ST_NXI = 12'b000000000010,
		ST_RDI = 12'b000000000100, ST_NXJ = 12'b000000001000,
		ST_RDJ = 12'b000000010000, ST_MUL = 12'b000000100000,
		ST_UNI = 12'b000001000000, ST_TEST = 12'b000010000000,
		ST_SCAN = 12'b000100000000, ST_EMIT = 12'b001000000000,
		ST_ERD = 12'b010000000000, ST_OUT = 12'b100000000000
	} state_t;

	localparam int AB = 2*CoordBits;
	localparam int UB = AB + 1;
	localparam int RW = UB + gbs_pkg::ThrBits;

	state_t st_q;
	logic [CW-1:0] n_q, i_q, j_q, o_q, last_q;
	logic ovf_q;
	logic [MaxBoxes-1:0] sup_q;
	logic [BW-1:0] bi_q;
	logic [CoordBits-1:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
	logic [AB-1:0] inter_q, areaa_q, areab_q;
	logic [UB-1:0] uni_q;
	logic [RW-1:0] lhs_q;
	logic [RW-1:0] rhs;
	logic hit;

	function automatic logic [CoordBits-1:0] span(input logic [CoordBits-1:0] lo,
		input logic [CoordBits-1:0] hi);
		return hi > lo ? hi - lo : '0;
	endfunction

	logic [CoordBits-1:0] pl, pt, pr, pb, ql, qt, qr, qb;
	assign {pb, pr, pt, pl} = bi_q;
	assign {qb, qr, qt, ql} = rdata;

	assign busy = st_q != ST_IDLE;
	assign req_ready = st_q == ST_IDLE;

	assign rhs = RW'(uni_q) * RW'(thr);
	assign hit = uni_q != '0 && lhs_q >= rhs;

	always_comb begin
		case (st_q)
			ST_NXI: raddr = i_q[AW-1:0];
			ST_NXJ: raddr = j_q[AW-1:0];
			default: raddr = o_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			sup_q <= '0;
			out_valid <= 1'b0;
			out_idx <= '0; out_box <= '0; out_ovf <= 1'b0; out_last <= 1'b0;
			n_q <= '0; i_q <= '0; j_q <= '0; o_q <= '0; last_q <= '0; ovf_q <= 1'b0;
			bi_q <= '0;
			iw_q <= '0; ih_q <= '0; aw_q <= '0; ah_q <= '0; bw_q <= '0; bh_q <= '0;
			inter_q <= '0; areaa_q <= '0; areab_q <= '0;
			uni_q <= '0; lhs_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						n_q <= req_count;
						ovf_q <= req_ovf;
						i_q <= '0;
						st_q <= ST_NXI;
					end
				end
				ST_NXI: begin
					if (i_q >= n_q) begin
						i_q <= '0;
						last_q <= '0;
						st_q <= ST_SCAN;
					end else if (sup_q[i_q[AW-1:0]] || i_q + CW'(1) >= n_q) begin
						i_q <= i_q + CW'(1);
					end else begin
						st_q <= ST_RDI;
					end
				end
				ST_RDI: begin
					bi_q <= rdata;
					j_q <= i_q + CW'(1);
					st_q <= ST_NXJ;
				end
				ST_NXJ: begin
					if (j_q >= n_q) begin
						i_q <= i_q + CW'(1);
						st_q <= ST_NXI;
					end else if (sup_q[j_q[AW-1:0]]) begin
						j_q <= j_q + CW'(1);
					end else begin
						st_q <= ST_RDJ;
					end
				end
				ST_RDJ: begin
					iw_q <= span(pl > ql ? pl : ql, pr < qr ? pr : qr);
					ih_q <= span(pt > qt ? pt : qt, pb < qb ? pb : qb);
					aw_q <= span(pl, pr); ah_q <= span(pt, pb);
					bw_q <= span(ql, qr); bh_q <= span(qt, qb);
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					inter_q <= AB'(iw_q) * AB'(ih_q);
					areaa_q <= AB'(aw_q) * AB'(ah_q);
					areab_q <= AB'(bw_q) * AB'(bh_q);
					st_q <= ST_UNI;
				end
				ST_UNI: begin
					uni_q <= UB'(areaa_q) + UB'(areab_q) - UB'(inter_q);
					lhs_q <= {2'b00, inter_q, 8'd0};
					st_q <= ST_TEST;
				end
				ST_TEST: begin
					if (hit) begin
						sup_q[j_q[AW-1:0]] <= 1'b1;
					end
					j_q <= j_q + CW'(1);
					st_q <= ST_NXJ;
				end
				ST_SCAN: begin
					if (i_q < n_q) begin
						if (!sup_q[i_q[AW-1:0]]) last_q <= i_q;
						i_q <= i_q + CW'(1);
					end else begin
						o_q <= '0;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (o_q >= n_q) begin
						st_q <= ST_IDLE;
					end else if (sup_q[o_q[AW-1:0]]) begin
						sup_q[o_q[AW-1:0]] <= 1'b0;
						o_q <= o_q + CW'(1);
					end else begin
						st_q <= ST_ERD;
					end
				end
				ST_ERD: begin
					out_box <= rdata;
					out_idx <= o_q[AW-1:0];
					out_last <= o_q == last_q;
					out_ovf <= ovf_q;
					out_valid <= 1'b1;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						o_q <= o_q + CW'(1);
						st_q <= ST_EMIT;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !out_valid) else $error("result while idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> busy) else $error("request not taken");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_box) && $stable(out_idx))
		else $error("result changed while waiting");
`endif
endmodule

### rtl/greedy_box_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression
// Boxes are loaded one per cycle while the input is ready, in falling score
// order, until a request marked last arrives. The set is then suppressed
// pair by pair in one shared unit, each tested pair passing through the
// RDJ, MUL, UNI and TEST states. A scan then finds the final survivor, and
// the output walk emits each kept box, holding it for as long as the
// receiver stalls. The input is not ready from the last request of a set
// until that output walk has ended.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
	parameter int MaxBoxes = gbs_pkg::MaxBoxesDefault,
	parameter int CoordBits = gbs_pkg::CoordBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [gbs_pkg::ThrBits-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CoordBits-1:0] box_left,
	input  logic [CoordBits-1:0] box_top,
	input  logic [CoordBits-1:0] box_right,
	input  logic [CoordBits-1:0] box_bottom,
	input  logic                 is_last_box,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [gbs_pkg::IndexBits-1:0] kept_index,
	output logic [CoordBits-1:0] kept_left,
	output logic [CoordBits-1:0] kept_top,
	output logic [CoordBits-1:0] kept_right,
	output logic [CoordBits-1:0] kept_bottom,
	output logic                 overflowed,
	output logic                 is_last_kept
);
	localparam int AW = $clog2(MaxBoxes);
	localparam int CW = $clog2(MaxBoxes + 1);
	localparam int BW = 4*CoordBits;

	logic [gbs_pkg::ThrBits-1:0] thr_q;
	logic we, busy, req_valid, req_ready, req_ovf;
	logic [AW-1:0] waddr, raddr, oidx;
	logic [BW-1:0] wdata, rdata, obox;
	logic [CW-1:0] req_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= gbs_pkg::ThrReset;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	gbs_front #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_box({box_bottom, box_right, box_top, box_left}), .in_last(is_last_box),
		.set_busy(busy), .we, .waddr, .wdata,
		.req_valid, .req_ready, .req_count, .req_ovf);

	gbs_ram #(.Width(BW), .Depth(MaxBoxes)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata);

	gbs_back #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_back (
		.clk, .arst_n, .thr(thr_q), .req_valid, .req_ready, .req_count, .req_ovf,
		.busy, .raddr, .rdata, .out_valid, .out_ready, .out_idx(oidx),
		.out_box(obox), .out_ovf(overflowed), .out_last(is_last_kept));

	assign kept_index = gbs_pkg::IndexBits'(oidx);
	assign {kept_bottom, kept_right, kept_top, kept_left} = obox;
endmodule

### sim/tb_greedy_box_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_box_suppression: self-checking bench for greedy box suppression
// Sends sets of boxes through the request channel, predicts the surviving
// boxes of each set with a local suppression model and checks every kept box
// in order, field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_greedy_box_suppression;
	localparam int MaxB = gbs_pkg::MaxBoxesDefault;
	localparam int CB = gbs_pkg::CoordBitsDefault;
	localparam int IdleLimit = 200000;

	typedef struct packed {
		logic [CB-1:0] l, t, r, b;
		logic          last;
	} box_req_t;

	typedef struct packed {
		logic [gbs_pkg::IndexBits-1:0] idx;
		logic [CB-1:0]        l, t, r, b;
		logic                 ovf, last;
	} kept_box_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [gbs_pkg::ThrBits-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0, in_ready;
	logic [CB-1:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
	logic is_last_box = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic [gbs_pkg::IndexBits-1:0] kept_index;
	logic [CB-1:0] kept_left, kept_top, kept_right, kept_bottom;
	logic overflowed, is_last_kept;

	greedy_box_suppression dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.box_left(box_left), .box_top(box_top), .box_right(box_right),
		.box_bottom(box_bottom), .is_last_box(is_last_box),
		.out_valid(out_valid), .out_ready(out_ready), .kept_index(kept_index),
		.kept_left(kept_left), .kept_top(kept_top), .kept_right(kept_right),
		.kept_bottom(kept_bottom), .overflowed(overflowed),
		.is_last_kept(is_last_kept)
	);

	box_req_t pending_boxes[$];
	kept_box_t expected_kept[$];
	box_req_t set_store[MaxB];
	bit set_suppressed[MaxB];
	int set_count;
	bit set_overflow;
	logic [gbs_pkg::ThrBits-1:0] iou_thr;
	int error_count = 0;
	int send_gap = 0, recv_gap = 0, recv_hold = 0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned extent(longint unsigned lo, longint unsigned hi);
		return hi > lo ? hi - lo : 0;
	endfunction

	function automatic bit box_overlap(box_req_t p, box_req_t q,
		logic [gbs_pkg::ThrBits-1:0] thr);
		longint unsigned il, it, ir, ib, inter, uni;
		il = p.l > q.l ? p.l : q.l;
		it = p.t > q.t ? p.t : q.t;
		ir = p.r < q.r ? p.r : q.r;
		ib = p.b < q.b ? p.b : q.b;
		inter = extent(il, ir) * extent(it, ib);
		uni = extent(p.l, p.r) * extent(p.t, p.b) + extent(q.l, q.r) * extent(q.t, q.b)
			- inter;
		if (uni == 0) return 1'b0;
		return inter * 256 >= longint'(thr) * uni;
	endfunction

	task automatic queue_box(box_req_t bx);
		pending_boxes = {pending_boxes, bx};
	endtask

	task automatic predict_kept(box_req_t bx);
		int last_idx;
		kept_box_t k;
		if (set_count < MaxB) begin
			set_store[set_count] = bx;
			set_suppressed[set_count] = 1'b0;
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!bx.last) return;
		for (int i = 0; i < set_count; i++) begin
			if (set_suppressed[i]) continue;
			for (int j = i + 1; j < set_count; j++)
				if (!set_suppressed[j] && box_overlap(set_store[i], set_store[j], iou_thr))
					set_suppressed[j] = 1'b1;
		end
		last_idx = 0;
		for (int i = 0; i < set_count; i++)
			if (!set_suppressed[i]) last_idx = i;
		for (int i = 0; i < set_count; i++) begin
			if (set_suppressed[i]) continue;
			k.idx = i[gbs_pkg::IndexBits-1:0];
			k.l = set_store[i].l; k.t = set_store[i].t;
			k.r = set_store[i].r; k.b = set_store[i].b;
			k.ovf = set_overflow;
			k.last = (i == last_idx);
			expected_kept = {expected_kept, k};
		end
		set_count = 0;
		set_overflow = 1'b0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_kept({box_left, box_top, box_right, box_bottom, is_last_box});
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_boxes.size() > 0) begin
					box_req_t nx;
					nx = pending_boxes.pop_front();
					in_valid <= 1'b1;
					box_left <= nx.l; box_top <= nx.t;
					box_right <= nx.r; box_bottom <= nx.b;
					is_last_box <= nx.last;
					if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver idling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_kept.size() == 0) begin
					report_mismatch("unexpected kept_index", kept_index, -1);
				end else begin
					kept_box_t e;
					e = expected_kept.pop_front();
					if (kept_index !== e.idx) report_mismatch("kept_index", kept_index, e.idx);
					if (kept_left !== e.l) report_mismatch("kept_left", kept_left, e.l);
					if (kept_top !== e.t) report_mismatch("kept_top", kept_top, e.t);
					if (kept_right !== e.r) report_mismatch("kept_right", kept_right, e.r);
					if (kept_bottom !== e.b) report_mismatch("kept_bottom", kept_bottom, e.b);
					if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
					if (is_last_kept !== e.last)
						report_mismatch("is_last_kept", is_last_kept, e.last);
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("tb_greedy_box_suppression: done, errors");
			$finish;
		end
	end

	function automatic box_req_t rand_box(bit last, int span_max);
		box_req_t bx;
		int w, h;
		if ($urandom_range(0, 9) == 0) begin
			bx.l = CB'($urandom); bx.t = CB'($urandom);
			bx.r = CB'($urandom); bx.b = CB'($urandom);
		end else begin
			w = $urandom_range(0, span_max);
			h = $urandom_range(0, span_max);
			bx.l = CB'($urandom_range(0, 65535 - w));
			bx.t = CB'($urandom_range(0, 65535 - h));
			bx.r = CB'(bx.l + w);
			bx.b = CB'(bx.t + h);
		end
		bx.last = last;
		return bx;
	endfunction

	// Set of boxes clustered so that suppression actually happens.
	task automatic queue_set(int n);
		box_req_t base, bx;
		base = rand_box(1'b0, 200);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				bx = base;
				bx.l = CB'(base.l + $urandom_range(0, 20));
				bx.t = CB'(base.t + $urandom_range(0, 20));
				bx.r = CB'(base.r + $urandom_range(0, 20));
				bx.b = CB'(base.b + $urandom_range(0, 20));
				if (bx.r < bx.l) bx.r = bx.l;
				if (bx.b < bx.t) bx.b = bx.t;
			end else begin
				bx = rand_box(1'b0, $urandom_range(0, 1) ? 300 : 65535);
			end
			bx.last = (i == n - 1);
			queue_box(bx);
		end
	endtask

	task automatic drain_and_settle();
		while (pending_boxes.size() > 0 || in_valid || expected_kept.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_threshold(logic [gbs_pkg::ThrBits-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		iou_thr = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		box_req_t bx;
		int sent;
		logic [gbs_pkg::ThrBits-1:0] thr_list[5] = '{9'd0, 9'd256, 9'd511, 9'd64, 9'd200};
		set_count = 0;
		set_overflow = 1'b0;
		iou_thr = gbs_pkg::ThrReset;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets: single box, identical boxes, extremes, reversed and empty boxes.
		queue_box('{'0, '0, '0, '0, 1'b1});
		queue_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
		queue_box('{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0});
		queue_box('{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0});
		queue_box('{16'd0, 16'd0, 16'h7FFF, 16'hFFFF, 1'b0});
		queue_box('{16'd100, 16'd100, 16'd50, 16'd50, 1'b0});
		queue_box('{16'd100, 16'd100, 16'd50, 16'd50, 1'b0});
		queue_box('{16'h5555, 16'hAAAA, 16'hAAAA, 16'hFFFF, 1'b0});
		queue_box('{16'd10, 16'd10, 16'd20, 16'd20, 1'b0});
		queue_box('{16'd15, 16'd10, 16'd25, 16'd20, 1'b1});
		drain_and_settle();

		// Overflow: a set of more boxes than the store holds, ending on a dropped box.
		for (int i = 0; i < MaxB + 3; i++) begin
			bx = rand_box(i == MaxB + 2, 1000);
			queue_box(bx);
		end
		drain_and_settle();

		// Long receiver hold while the sender keeps offering, so the block backs up.
		recv_hold = 3000;
		queue_set(5); queue_set(4); queue_set(6);
		drain_and_settle();

		sent = 10 + MaxB + 3 + 15;
		foreach (thr_list[k]) begin
			write_threshold(thr_list[k]);
			for (int s = 0; s < 8; s++) begin
				int n;
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
				queue_set(n);
				sent += n;
			end
			// Sender pauses here until every kept box of these sets has come.
			drain_and_settle();
		end
		write_threshold(gbs_pkg::ThrReset);
		quiet = 1'b1;
		while (sent < 320) begin
			int n;
			n = $urandom_range(1, 6);
			queue_set(n);
			sent += n;
		end
		drain_and_settle();

		if (error_count == 0) begin
			$display("tb_greedy_box_suppression: done, clean");
		end else begin
			$display("tb_greedy_box_suppression: done, errors");
		end
		$finish;
	end
endmodule
